// File: hw/rtl/owtr_pkg.sv
// Shared types, constants and helper functions for the one-wire temperature reader.
`timescale 1ns / 1ps

package owtr_pkg;

	localparam int TICK_COUNT_BITS = 16;
	localparam int DUR_W           = 16;
	localparam int GAP_W           = 8;
	localparam int CMP_W           = (TICK_COUNT_BITS > DUR_W) ? TICK_COUNT_BITS : DUR_W;
	localparam int XFER_W          = 3;
	localparam int BIT_W           = 3;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int TEMP_W          = 16;
	localparam int IN_DATA_W       = 8;
	localparam int OUT_DATA_W      = 24;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_TAIL = 4'd3,
		PH_W_LOW    = 4'd4,
		PH_W_HOLD   = 4'd5,
		PH_R_LOW    = 4'd6,
		PH_R_WAIT   = 4'd7,
		PH_R_HOLD   = 4'd8
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESET_LOW     = 3'd0,
		CFG_PRESENCE_WAIT = 3'd1,
		CFG_PRESENCE_TAIL = 3'd2,
		CFG_SLOT_HOLD     = 3'd3,
		CFG_SHORT_GAP     = 3'd4
	} cfg_idx_t;

	localparam logic [XFER_W-1:0] XFER_FIRST_RESET  = 3'd0;
	localparam logic [XFER_W-1:0] XFER_SECOND_RESET = 3'd3;
	localparam logic [XFER_W-1:0] XFER_LOW_BYTE     = 3'd6;
	localparam logic [XFER_W-1:0] XFER_HIGH_BYTE    = 3'd7;

	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_PAD = 8'hBE;

	localparam logic [DUR_W-1:0] RESET_LOW_INIT     = 16'd75;
	localparam logic [DUR_W-1:0] PRESENCE_WAIT_INIT = 16'd4;
	localparam logic [DUR_W-1:0] PRESENCE_TAIL_INIT = 16'd20;
	localparam logic [DUR_W-1:0] SLOT_HOLD_INIT     = 16'd10;
	localparam logic [GAP_W-1:0] SHORT_GAP_INIT     = 8'd1;

	function automatic logic [7:0] cmd_code(input logic [XFER_W-1:0] t);
		logic [7:0] c;
		case (t)
			3'd1, 3'd4: c = CMD_SKIP_ROM;
			3'd2:       c = CMD_CONVERT;
			3'd5:       c = CMD_READ_PAD;
			default:    c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic phase_t xfer_phase(input logic [XFER_W-1:0] t);
		phase_t p;
		if (t == XFER_FIRST_RESET || t == XFER_SECOND_RESET) begin
			p = PH_RST_LOW;
		end else if (t >= XFER_LOW_BYTE) begin
			p = PH_R_LOW;
		end else begin
			p = PH_W_LOW;
		end
		return p;
	endfunction

	function automatic logic drive_of(input phase_t p, input logic lsb);
		logic d;
		case (p)
			PH_RST_LOW, PH_W_LOW, PH_R_LOW: d = 1'b1;
			PH_W_HOLD:                      d = ~lsb;
			default:                        d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/onewire_temperature_reader.sv
// Top level of the one-wire temperature reader: bus sequencer and result register.
`timescale 1ns / 1ps

// One step per accepted item, one item per clock while the sink takes results: each
// tick or start request is processed in the cycle it is accepted, and its result appears
// in the output register on the next cycle. The input side stays ready while the
// output register is empty or being drained, so the rate is one item per cycle
// whenever the sink takes results. Configuration writes are always accepted.
module onewire_temperature_reader import owtr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] line_level, [7:1] zero
	input  logic [0:0]            s_tuser,   // [0] op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] no_device,
	                                         // [18:3] temperature, [23:19] zero
	output logic                  m_tlast,   // done_res
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DUR_W-1:0] reset_low_q, presence_wait_q, presence_tail_q, slot_hold_q;
	logic [GAP_W-1:0] short_gap_q;

	phase_t                     phase_q, phase_d;
	logic [XFER_W-1:0]          xfer_q, xfer_d;
	logic [BIT_W-1:0]           bit_q, bit_d;
	logic [TICK_COUNT_BITS-1:0] cnt_q, cnt_d, step_cnt;
	logic [7:0]                 shift_q, shift_d, low_q, low_d;
	logic [TEMP_W-1:0]          result_q, result_d;
	logic                       err_q, err_d;

	logic             s_accept, op, line, hit, done, drive, xfer_end;
	logic [DUR_W-1:0] dur;

	logic                  m_tvalid_q, m_tlast_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = ~m_tvalid_q | m_tready;
	assign s_accept  = s_tvalid & s_tready;
	assign op        = s_tuser[0];
	assign line      = s_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q     <= RESET_LOW_INIT;
			presence_wait_q <= PRESENCE_WAIT_INIT;
			presence_tail_q <= PRESENCE_TAIL_INIT;
			slot_hold_q     <= SLOT_HOLD_INIT;
			short_gap_q     <= SHORT_GAP_INIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RESET_LOW:     reset_low_q     <= cfg_data;
				CFG_PRESENCE_WAIT: presence_wait_q <= cfg_data;
				CFG_PRESENCE_TAIL: presence_tail_q <= cfg_data;
				CFG_SLOT_HOLD:     slot_hold_q     <= cfg_data;
				CFG_SHORT_GAP:     short_gap_q     <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d  = phase_q;
		xfer_d   = xfer_q;
		bit_d    = bit_q;
		cnt_d    = cnt_q;
		shift_d  = shift_q;
		low_d    = low_q;
		result_d = result_q;
		err_d    = err_q;
		done     = 1'b0;
		xfer_end = 1'b0;
		step_cnt = cnt_q + TICK_COUNT_BITS'(1);

		case (phase_q)
			PH_RST_LOW:                   dur = reset_low_q;
			PH_RST_WAIT:                  dur = presence_wait_q;
			PH_RST_TAIL:                  dur = presence_tail_q;
			PH_W_LOW, PH_R_LOW, PH_R_WAIT: dur = DUR_W'(short_gap_q);
			PH_W_HOLD, PH_R_HOLD:         dur = slot_hold_q;
			default:                      dur = '0;
		endcase
		hit = (CMP_W'(step_cnt) >= CMP_W'(dur)) || (&step_cnt);

		if (op) begin
			if (phase_q == PH_IDLE) begin
				xfer_d  = XFER_FIRST_RESET;
				cnt_d   = '0;
				bit_d   = '0;
				phase_d = PH_RST_LOW;
			end
			drive = (phase_q == PH_IDLE) ? 1'b1 : drive_of(phase_q, shift_q[0]);
		end else begin
			drive = drive_of(phase_q, shift_q[0]);
			if (phase_q != PH_IDLE) begin
				cnt_d = hit ? '0 : step_cnt;
			end
			unique case (phase_q)
				PH_IDLE: ;
				PH_RST_LOW: begin
					if (hit) phase_d = PH_RST_WAIT;
				end
				PH_RST_WAIT: begin
					if (hit) begin
						if (xfer_q == XFER_FIRST_RESET && line) begin
							err_d    = 1'b1;
							result_d = '0;
							phase_d  = PH_IDLE;
							xfer_d   = XFER_FIRST_RESET;
							done     = 1'b1;
						end else begin
							phase_d = PH_RST_TAIL;
						end
					end
				end
				PH_RST_TAIL: begin
					if (hit) xfer_end = 1'b1;
				end
				PH_W_LOW: begin
					if (hit) phase_d = PH_W_HOLD;
				end
				PH_W_HOLD: begin
					if (hit) begin
						shift_d = shift_q >> 1;
						bit_d   = bit_q + BIT_W'(1);
						if (bit_d == '0) xfer_end = 1'b1;
						else phase_d = PH_W_LOW;
					end
				end
				PH_R_LOW: begin
					if (hit) phase_d = PH_R_WAIT;
				end
				PH_R_WAIT: begin
					if (hit) begin
						shift_d = {line, shift_q[7:1]};
						phase_d = PH_R_HOLD;
					end
				end
				PH_R_HOLD: begin
					if (hit) begin
						bit_d = bit_q + BIT_W'(1);
						if (bit_d == '0) xfer_end = 1'b1;
						else phase_d = PH_R_LOW;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		if (xfer_end) begin
			if (xfer_q == XFER_LOW_BYTE) low_d = shift_d;
			if (xfer_q == XFER_HIGH_BYTE) begin
				result_d = {shift_d, low_q};
				err_d    = 1'b0;
				phase_d  = PH_IDLE;
				xfer_d   = XFER_FIRST_RESET;
				done     = 1'b1;
			end else begin
				xfer_d  = xfer_q + XFER_W'(1);
				cnt_d   = '0;
				bit_d   = '0;
				phase_d = xfer_phase(xfer_d);
				if (phase_d != PH_RST_LOW) shift_d = cmd_code(xfer_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			xfer_q   <= '0;
			bit_q    <= '0;
			cnt_q    <= '0;
			shift_q  <= '0;
			low_q    <= '0;
			result_q <= '0;
			err_q    <= 1'b0;
		end else if (s_accept) begin
			phase_q  <= phase_d;
			xfer_q   <= xfer_d;
			bit_q    <= bit_d;
			cnt_q    <= cnt_d;
			shift_q  <= shift_d;
			low_q    <= low_d;
			result_q <= result_d;
			err_q    <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_tdata_q <= {5'b0, result_d, err_d, (phase_d != PH_IDLE), drive};
			m_tlast_q <= done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: hw/rtl/owtr_checker.sv
// Port-level checker for the one-wire temperature reader, bound to the top level.
`timescale 1ns / 1ps

module owtr_checker import owtr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast,
	input logic                  cfg_ready
);

	a_last_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[1])
		else $error("transfer ending a run still shows busy");

	a_error_zero_temp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[18:3] == '0)
		else $error("no-device result carries a nonzero temperature");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready && cfg_ready)
		else $error("input stalled while the result register can take a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind onewire_temperature_reader owtr_checker u_owtr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_ready (cfg_ready)
);
